### hdl/iss_pkg.sv
// shared types and constants of the insertion sorter
package iss_pkg;

	localparam int DEPTH  = 16;
	localparam int DATA_W = 32;

	typedef logic signed [DATA_W-1:0] data_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_DRAIN
	} cell_op_t;

	typedef enum logic {
		ST_FILL,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		data_t value;
		logic  valid;
		logic  shift;
	} cell_link_t;

	typedef struct packed {
		cell_op_t op;
		data_t    value;
		logic     descending;
	} cell_ctrl_t;

	// virtual neighbours at the two ends of the row
	localparam cell_link_t LINK_HEAD = '{value: '0, valid: 1'b1, shift: 1'b0};
	localparam cell_link_t LINK_TAIL = '{value: '0, valid: 1'b0, shift: 1'b0};

endpackage

### hdl/iss_if.sv
// handshake channels of the insertion sorter

interface iss_item_if;
	logic               valid;
	logic               ready;
	iss_pkg::data_t     value;
	logic               batch_end;

	modport source (output valid, output value, output batch_end, input ready);
	modport sink   (input valid, input value, input batch_end, output ready);
endinterface

interface iss_result_if;
	logic               valid;
	logic               ready;
	iss_pkg::data_t     sorted_value;
	logic               final_result;
	logic               overflow;

	modport source (output valid, output sorted_value, output final_result,
		output overflow, input ready);
	modport sink   (input valid, input sorted_value, input final_result,
		input overflow, output ready);
endinterface

interface iss_cfg_if;
	logic valid;
	logic ready;
	logic data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### hdl/iss_cell.sv
// one cell of the insertion chain: holds a value and its valid bit
module iss_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  iss_pkg::cell_ctrl_t ctrl,
	input  iss_pkg::cell_link_t prev_link,
	input  iss_pkg::cell_link_t next_link,
	output iss_pkg::cell_link_t link
);

	iss_pkg::data_t value_q;
	logic           valid_q;
	logic           passes;
	logic           shift;

	always_comb begin
		if (ctrl.descending) begin
			passes = value_q < ctrl.value;
		end else begin
			passes = value_q > ctrl.value;
		end
		// moves up only if every held value above it moves too
		shift = valid_q && passes && (next_link.shift || !next_link.valid);
	end

	assign link = '{value: value_q, valid: valid_q, shift: shift};

	always_ff @(posedge clk) begin
		case (ctrl.op)
			iss_pkg::CELL_INSERT: begin
				if (prev_link.shift) begin
					value_q <= prev_link.value;
				end else if (shift || (!valid_q && prev_link.valid)) begin
					value_q <= ctrl.value;
				end
			end
			iss_pkg::CELL_DRAIN: begin
				value_q <= next_link.value;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (ctrl.op)
				iss_pkg::CELL_INSERT: begin
					if (prev_link.valid) begin
						valid_q <= 1'b1;
					end
				end
				iss_pkg::CELL_DRAIN: begin
					valid_q <= next_link.valid;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

### hdl/insertion_sorter.sv
// top level of the insertion sorter: cell row, fill/drain control, ports
// While filling, one item is taken every cycle: all cells compare the incoming
// value at once and the ones that pass shift up by one place in the same cycle.
// Values of a batch beyond DEPTH (16) are dropped and every result of that batch
// carries overflow. The item flagged batch_end is inserted like any other; then
// the row drains through its head cell, one result beat per cycle while the
// result side is ready, for the n values held, while no item is taken. The
// descending register may be written at any time between batches and applies
// from the next insertion.
module insertion_sorter (
	input  logic clk,
	input  logic arst_n,
	iss_cfg_if.sink      cfg,
	iss_item_if.sink     items,
	iss_result_if.source results
);

	iss_pkg::state_t     state_q;
	iss_pkg::state_t     state_d;
	logic                descending_q;
	logic                dropped_q;
	logic                item_beat;
	logic                result_beat;
	logic                full;
	logic                last_beat;
	iss_pkg::cell_ctrl_t ctrl;
	iss_pkg::cell_link_t link      [iss_pkg::DEPTH];
	iss_pkg::cell_link_t prev_link [iss_pkg::DEPTH];
	iss_pkg::cell_link_t next_link [iss_pkg::DEPTH];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			descending_q <= 1'b0;
		end else if (cfg.valid) begin
			descending_q <= cfg.data;
		end
	end

	assign full        = link[iss_pkg::DEPTH-1].valid;
	assign last_beat   = !link[1].valid;
	assign item_beat   = items.valid && items.ready;
	assign result_beat = results.valid && results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iss_pkg::ST_FILL;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		items.ready     = 1'b0;
		results.valid   = 1'b0;
		ctrl.op         = iss_pkg::CELL_HOLD;
		ctrl.value      = items.value;
		ctrl.descending = descending_q;
		case (state_q)
			iss_pkg::ST_FILL: begin
				items.ready = 1'b1;
				if (item_beat) begin
					if (!full) begin
						ctrl.op = iss_pkg::CELL_INSERT;
					end
					if (items.batch_end) begin
						state_d = iss_pkg::ST_DRAIN;
					end
				end
			end
			iss_pkg::ST_DRAIN: begin
				results.valid = 1'b1;
				if (result_beat) begin
					ctrl.op = iss_pkg::CELL_DRAIN;
					if (last_beat) begin
						state_d = iss_pkg::ST_FILL;
					end
				end
			end
			default: begin
				state_d = iss_pkg::ST_FILL;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dropped_q <= 1'b0;
		end else if (item_beat && full) begin
			dropped_q <= 1'b1;
		end else if (result_beat && last_beat) begin
			dropped_q <= 1'b0;
		end
	end

	for (genvar i = 0; i < iss_pkg::DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign prev_link[i] = iss_pkg::LINK_HEAD;
		end else begin : g_body
			assign prev_link[i] = link[i-1];
		end
		if (i == iss_pkg::DEPTH - 1) begin : g_tail
			assign next_link[i] = iss_pkg::LINK_TAIL;
		end else begin : g_inner
			assign next_link[i] = link[i+1];
		end

		iss_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.prev_link (prev_link[i]),
			.next_link (next_link[i]),
			.link      (link[i])
		);
	end

	assign results.sorted_value = link[0].value;
	assign results.final_result = last_beat;
	assign results.overflow     = dropped_q;

endmodule

### tb/insertion_sorter_tb.sv
// testbench of the insertion sorter: directed and random batches checked beat by beat
`timescale 1ns / 100ps

module insertion_sorter_tb;

	typedef enum bit {
		ORDER_ASC,
		ORDER_DESC
	} sort_order_t;

	typedef enum int {
		RX_ALWAYS,
		RX_RANDOM,
		RX_PERIODIC,
		RX_LONG
	} rx_mode_t;

	typedef struct packed {
		iss_pkg::data_t sorted_value;
		logic           final_result;
		logic           overflow;
	} sorted_beat_t;

	localparam iss_pkg::data_t VAL_MAX = 32'sh7FFF_FFFF;
	localparam iss_pkg::data_t VAL_MIN = 32'sh8000_0000;

	logic clk;
	logic arst_n;

	iss_cfg_if    cfg_bus ();
	iss_item_if   item_bus ();
	iss_result_if result_bus ();

	insertion_sorter i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_bus),
		.items   (item_bus),
		.results (result_bus)
	);

	// software copy of the cell row
	iss_pkg::data_t model_row[$];
	bit             model_dropped;
	bit             model_desc;
	sorted_beat_t   pending_sorted[$];

	rx_mode_t rx_mode = RX_ALWAYS;
	int       rx_phase;
	int       rx_hold;
	bit       tx_idle_en;
	int       burst_left;

	int fail_count;
	int items_sent;
	int batches_sent;
	int overflow_batches;
	int desc_batches;
	int beats_checked;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// result side stall patterns
	always @(posedge clk) begin
		case (rx_mode)
			RX_ALWAYS: begin
				result_bus.ready <= 1'b1;
			end
			RX_RANDOM: begin
				result_bus.ready <= ($urandom_range(99) < 65);
			end
			RX_PERIODIC: begin
				rx_phase <= (rx_phase >= 6) ? 0 : rx_phase + 1;
				result_bus.ready <= (rx_phase < 4);
			end
			default: begin
				if (rx_hold <= 0) begin
					result_bus.ready <= ~result_bus.ready;
					rx_hold <= result_bus.ready ? $urandom_range(24, 1) : $urandom_range(6, 1);
				end else begin
					rx_hold <= rx_hold - 1;
				end
			end
		endcase
	end

	always @(posedge clk) begin
		sorted_beat_t want;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (pending_sorted.size() == 0) begin
				$error("unexpected result beat: sorted_value %0d", result_bus.sorted_value);
				fail_count++;
			end else begin
				want = pending_sorted.pop_front();
				if (result_bus.sorted_value !== want.sorted_value) begin
					$error("sorted_value: expected %0d, got %0d",
						want.sorted_value, result_bus.sorted_value);
					fail_count++;
				end
				if (result_bus.final_result !== want.final_result) begin
					$error("final_result: expected %0b, got %0b",
						want.final_result, result_bus.final_result);
					fail_count++;
				end
				if (result_bus.overflow !== want.overflow) begin
					$error("overflow: expected %0b, got %0b",
						want.overflow, result_bus.overflow);
					fail_count++;
				end
				beats_checked++;
			end
		end
	end

	function automatic void sort_model_take(input iss_pkg::data_t v, input logic last);
		int           pos;
		sorted_beat_t exp_beat;
		if (model_row.size() >= iss_pkg::DEPTH) begin
			model_dropped = 1'b1;
		end else begin
			pos = model_row.size();
			while (pos > 0 && (model_desc ? (model_row[pos-1] < v) : (model_row[pos-1] > v)))
				pos--;
			model_row.insert(pos, v);
		end
		if (last) begin
			foreach (model_row[k]) begin
				exp_beat.sorted_value = model_row[k];
				exp_beat.final_result = (k == model_row.size() - 1);
				exp_beat.overflow     = model_dropped;
				pending_sorted.push_back(exp_beat);
			end
			batches_sent++;
			if (model_dropped)
				overflow_batches++;
			if (model_desc)
				desc_batches++;
			model_row.delete();
			model_dropped = 1'b0;
		end
	endfunction

	task automatic send_item(input iss_pkg::data_t v, input logic last);
		item_bus.valid     <= 1'b1;
		item_bus.value     <= v;
		item_bus.batch_end <= last;
		@(posedge clk);
		while (!item_bus.ready)
			@(posedge clk);
		sort_model_take(v, last);
		items_sent++;
	endtask

	task automatic pace_sender();
		int gap;
		if (burst_left <= 0) begin
			gap = tx_idle_en ? $urandom_range(8) : 0;
			if (gap > 0) begin
				item_bus.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(12, 1);
		end
		burst_left--;
	endtask

	task automatic send_batch(input iss_pkg::data_t vals[$]);
		foreach (vals[i]) begin
			pace_sender();
			send_item(vals[i], i == vals.size() - 1);
		end
	endtask

	task automatic wait_drained();
		item_bus.valid <= 1'b0;
		@(posedge clk);
		while (pending_sorted.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_order(input sort_order_t ord);
		cfg_bus.valid <= 1'b1;
		cfg_bus.data  <= ord;
		@(posedge clk);
		while (!cfg_bus.ready)
			@(posedge clk);
		cfg_bus.valid <= 1'b0;
		model_desc = (ord == ORDER_DESC);
		@(posedge clk);
	endtask

	function automatic iss_pkg::data_t pick_value(input int style);
		case (style)
			0: return iss_pkg::data_t'($urandom);
			1: return iss_pkg::data_t'(int'($urandom_range(16)) - 8);
			2: begin
				case ($urandom_range(5))
					0: return VAL_MAX;
					1: return VAL_MIN;
					2: return iss_pkg::data_t'(0);
					3: return iss_pkg::data_t'(-1);
					4: return iss_pkg::data_t'(1);
					default: return iss_pkg::data_t'($urandom);
				endcase
			end
			default: return ($urandom_range(1)) ? iss_pkg::data_t'($urandom) : pick_value(2);
		endcase
	endfunction

	task automatic test_extremes();
		iss_pkg::data_t vals[$];
		vals = '{VAL_MAX, iss_pkg::data_t'(-1), VAL_MIN, iss_pkg::data_t'(0), VAL_MAX,
			iss_pkg::data_t'(1)};
		rx_mode = RX_ALWAYS;
		tx_idle_en = 1'b0;
		write_order(ORDER_ASC);
		send_batch(vals);
		wait_drained();
	endtask

	task automatic test_single_item();
		iss_pkg::data_t vals[$];
		vals = '{VAL_MIN};
		rx_mode = RX_RANDOM;
		write_order(ORDER_DESC);
		send_batch(vals);
		wait_drained();
	endtask

	// seventeen items: the flagged one arrives with the row full and is dropped
	task automatic test_full_overflow();
		iss_pkg::data_t vals[$];
		vals = '{VAL_MIN, VAL_MAX};
		while (vals.size() < iss_pkg::DEPTH)
			vals.push_back(pick_value(3));
		vals.push_back(VAL_MAX);
		rx_mode = RX_PERIODIC;
		tx_idle_en = 1'b1;
		send_batch(vals);
		wait_drained();
	endtask

	task automatic test_random_phases();
		sort_order_t    orders[6] = '{ORDER_DESC, ORDER_ASC, ORDER_DESC,
			ORDER_ASC, ORDER_DESC, ORDER_ASC};
		rx_mode_t       modes[6]  = '{RX_ALWAYS, RX_RANDOM, RX_LONG,
			RX_PERIODIC, RX_RANDOM, RX_LONG};
		iss_pkg::data_t vals[$];
		int             phase_items;
		int             len;
		int             pick;
		int             style;
		for (int ph = 0; ph < 6; ph++) begin
			write_order(orders[ph]);
			rx_mode = modes[ph];
			tx_idle_en = (ph != 0);
			burst_left = 0;
			phase_items = 0;
			while (phase_items < 27) begin
				pick = $urandom_range(99);
				if (pick < 10)
					len = iss_pkg::DEPTH;
				else if (pick < 18)
					len = iss_pkg::DEPTH + $urandom_range(4, 1);
				else if (pick < 28)
					len = 1;
				else
					len = $urandom_range(iss_pkg::DEPTH - 1, 2);
				style = $urandom_range(3);
				vals.delete();
				repeat (len) vals.push_back(pick_value(style));
				send_batch(vals);
				phase_items += len;
			end
			wait_drained();
		end
	endtask

	initial begin
		arst_n             <= 1'b0;
		cfg_bus.valid      <= 1'b0;
		cfg_bus.data       <= 1'b0;
		item_bus.valid     <= 1'b0;
		item_bus.value     <= '0;
		item_bus.batch_end <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_single_item();
		test_full_overflow();
		test_random_phases();

		while (pending_sorted.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d items in %0d batches (%0d overflowed, %0d sorted descending),",
			items_sent, batches_sent, overflow_batches, desc_batches);
		$display("checked %0d result beats under four receiver stall patterns",
			beats_checked);
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
